@@ sv/ksd_pkg.sv @@
package ksd_pkg;

    localparam int HIST_LEN   = 8;
    localparam int FILL_W     = 4;
    localparam int KEY_W      = 8;
    localparam int NUM_PAT    = 4;
    localparam int LEN_W      = 4;
    localparam int PAT_W      = 64;
    localparam int LENS_W     = NUM_PAT * LEN_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 8;
    localparam int BYTE_SEL_W = 3;

    typedef enum logic {
        OP_KEY   = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEYS_A  = 3'd0,
        REG_KEYS_B  = 3'd1,
        REG_KEYS_C  = 3'd2,
        REG_KEYS_D  = 3'd3,
        REG_LENGTHS = 3'd4,
        REG_ENABLE  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
    } item_t;

    typedef struct packed {
        logic [NUM_PAT-1:0][PAT_W-1:0] keys;
        logic [LENS_W-1:0]             lengths;
        logic [NUM_PAT-1:0]            enable;
    } cfg_t;

endpackage

@@ sv/key_sequence_detector.sv @@
// Key sequence detector.
// Input stream (s_*): one transfer per key press or flush command.
//   s_tuser[0] is the command (0 press, 1 flush); s_tdata carries the key code.
// Output stream (m_*): exactly one transfer per input transfer, in order.
//   m_tdata[3:0] is the match mask, bit p set when enabled pattern p equals
//   the most recent presses; a flush returns an all-zero mask.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
//   (0..3 pattern keys, 4 lengths, 5 enable); write only while idle.
// Pipeline: a result passes the input stage, the two-entry queue and the
//   history/compare stage with its output register, in that order.
// Throughput: one item per cycle while m_tready stays high; the history
//   update and parallel compare in the back stage set that figure.
// Stall: when m_tready is low the result holds, the queue fills and then
//   s_tready drops; nothing is dropped or repeated.
// Reset: aresetn (synchronous, active low) clears configuration, history,
//   fill count, queue and valid flags; the block is ready next cycle.
module key_sequence_detector
    import ksd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,    // [7:0] key_code
    input  logic [0:0]            s_tuser,    // [0] command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,    // [3:0] match_mask, [7:4] zero
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  q_push;
    logic  q_full;
    item_t q_in_item;
    logic  q_pop;
    logic  q_valid;
    item_t q_out_item;

    // configuration registers; indexes beyond the list are ignored
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_KEYS_A:  cfg_next.keys[0] = cfg_wdata[PAT_W-1:0];
                REG_KEYS_B:  cfg_next.keys[1] = cfg_wdata[PAT_W-1:0];
                REG_KEYS_C:  cfg_next.keys[2] = cfg_wdata[PAT_W-1:0];
                REG_KEYS_D:  cfg_next.keys[3] = cfg_wdata[PAT_W-1:0];
                REG_LENGTHS: cfg_next.lengths = cfg_wdata[LENS_W-1:0];
                REG_ENABLE:  cfg_next.enable  = cfg_wdata[NUM_PAT-1:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accept and decode transfers
    ksd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in_item)
    );

    // queue: decouple front and back stalls
    ksd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (q_out_item)
    );

    // back: advance history, compare patterns, hold result
    ksd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_out_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ sv/ksd_fifo.sv @@
module ksd_fifo
    import ksd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  pop_valid,
    output item_t pop_item
);

    // two-entry queue between classifier and executor
    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_item  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/ksd_front.sv @@
module ksd_front
    import ksd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic [0:0]           s_tuser,
    input  logic                 q_full,
    output logic                 q_push,
    output item_t                q_item
);

    // input stage: capture and decode one transfer, hand it to the queue
    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  accept;

    assign q_push   = valid_reg;
    assign q_item   = item_reg;
    assign s_tready = !valid_reg || !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        item_next = item_reg;
        if (accept) begin
            item_next.op  = s_tuser[0] ? OP_FLUSH : OP_KEY;
            item_next.key = s_tuser[0] ? '0 : s_tdata[KEY_W-1:0];
        end
        valid_next = accept || (valid_reg && q_full);
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule

@@ sv/ksd_back.sv @@
module ksd_back
    import ksd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic                  q_valid,
    input  item_t                 q_item,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic [HIST_LEN-1:0][KEY_W-1:0] hist_reg;
    logic [HIST_LEN-1:0][KEY_W-1:0] hist_next;
    logic [FILL_W-1:0]              fill_reg;
    logic [FILL_W-1:0]              fill_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [NUM_PAT-1:0]             mask_reg;
    logic [NUM_PAT-1:0]             mask_next;

    // take an item when the output register is free or drains this cycle
    assign q_pop    = q_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-NUM_PAT){1'b0}}, mask_reg};

    always_comb begin
        logic [LEN_W-1:0]      len;
        logic [LEN_W-1:0]      idx;
        logic [BYTE_SEL_W-1:0] sel;
        logic                  ok;

        hist_next = hist_reg;
        fill_next = fill_reg;
        mask_next = mask_reg;
        len       = '0;
        idx       = '0;
        sel       = '0;
        ok        = 1'b0;

        if (q_pop) begin
            if (q_item.op == OP_FLUSH) begin
                hist_next = '0;
                fill_next = '0;
                mask_next = '0;
            end else begin
                // shift in the new press at the newest position
                hist_next[0] = q_item.key;
                for (int k = 1; k < HIST_LEN; k++) begin
                    hist_next[k] = hist_reg[k-1];
                end
                if (fill_reg < FILL_W'(HIST_LEN)) begin
                    fill_next = fill_reg + FILL_W'(1);
                end

                for (int p = 0; p < NUM_PAT; p++) begin
                    len = cfg.lengths[p*LEN_W +: LEN_W];
                    ok  = cfg.enable[p] && (len <= LEN_W'(HIST_LEN))
                          && (len <= fill_next);
                    for (int j = 0; j < HIST_LEN; j++) begin
                        idx = len - LEN_W'(1) - LEN_W'(j);
                        sel = idx[BYTE_SEL_W-1:0];
                        if ((LEN_W'(j) < len)
                            && (hist_next[j] != cfg.keys[p][{sel, 3'b000} +: KEY_W])) begin
                            ok = 1'b0;
                        end
                    end
                    mask_next[p] = ok;
                end
            end
        end

        out_valid_next = q_pop || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        mask_reg <= mask_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            hist_reg      <= hist_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ dv/key_sequence_detector_tb.sv @@
`timescale 1ns / 1ps

module key_sequence_detector_tb;
    import ksd_pkg::*;

    // Predicts the match mask of every accepted transfer from a private copy
    // of the pattern registers and the press history, and checks the
    // returned masks against those predictions in order.
    class match_scoreboard;
        logic [PAT_W-1:0]   pat_keys [NUM_PAT];
        logic [LEN_W-1:0]   pat_len  [NUM_PAT];
        logic [NUM_PAT-1:0] pat_en;
        logic [KEY_W-1:0]   recent   [HIST_LEN];
        int unsigned        fill;
        logic [NUM_PAT-1:0] pending_masks [$];
        int                 errors;

        function new();
            for (int p = 0; p < NUM_PAT; p++) begin
                pat_keys[p] = '0;
                pat_len[p]  = '0;
            end
            pat_en = '0;
            for (int j = 0; j < HIST_LEN; j++) recent[j] = '0;
            fill   = 0;
            errors = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_KEYS_A:  pat_keys[0] = value;
                REG_KEYS_B:  pat_keys[1] = value;
                REG_KEYS_C:  pat_keys[2] = value;
                REG_KEYS_D:  pat_keys[3] = value;
                REG_LENGTHS: begin
                    for (int p = 0; p < NUM_PAT; p++) pat_len[p] = value[LEN_W*p +: LEN_W];
                end
                REG_ENABLE:  pat_en = value[NUM_PAT-1:0];
                default: ;
            endcase
        endfunction

        // Update the history for one accepted transfer and queue its mask.
        function void record_input(op_t op, logic [KEY_W-1:0] key);
            logic [NUM_PAT-1:0] mask;
            int unsigned        len;
            bit                 hit;
            mask = '0;
            if (op == OP_FLUSH) begin
                for (int j = 0; j < HIST_LEN; j++) recent[j] = '0;
                fill = 0;
            end else begin
                for (int j = HIST_LEN - 1; j > 0; j--) recent[j] = recent[j-1];
                recent[0] = key;
                if (fill < HIST_LEN) fill++;
                for (int p = 0; p < NUM_PAT; p++) begin
                    len = pat_len[p];
                    // oversized patterns and too short a history never match
                    hit = pat_en[p] && (len <= HIST_LEN) && (len <= fill);
                    if (hit) begin
                        for (int j = 0; j < len; j++) begin
                            if (recent[j] != pat_keys[p][8*(len-1-j) +: 8]) hit = 1'b0;
                        end
                    end
                    mask[p] = hit;
                end
            end
            pending_masks.push_back(mask);
        endfunction

        task report(string msg);
            $display("%0t MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task check_mask(logic [OUT_DATA_W-1:0] data);
            logic [NUM_PAT-1:0] want;
            if (pending_masks.size() == 0) begin
                report($sformatf("unexpected result, mask %h", data[NUM_PAT-1:0]));
            end else begin
                want = pending_masks.pop_front();
                if (data[NUM_PAT-1:0] !== want)
                    report($sformatf("match_mask %b, predicted %b", data[NUM_PAT-1:0], want));
            end
        endtask
    endclass

    // Every block input starts from a known value.
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;    // [7:0] key_code
    logic [0:0]            s_tuser   = '0;    // [0] command
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;           // [3:0] match_mask, [7:4] zero
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    match_scoreboard sb = new();
    bit              quiet = 1'b0;    // suppress idling on both sides
    int              items_sent = 0;

    key_sequence_detector uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Drive one transfer: idle for a random gap, present the item, hold it
    // until the handshake, then note it with the scoreboard. s_tvalid stays
    // high when the next call draws no gap.
    task automatic send_item(input op_t op, input logic [KEY_W-1:0] key);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= key;
        do @(posedge aclk); while (!s_tready);
        sb.record_input(op, key);
        items_sent++;
    endtask

    // Press the keys of pattern p oldest first; optionally flip one bit of
    // one randomly chosen key so the sequence breaks.
    task automatic play_pattern(input int p, input bit corrupt);
        int              len;
        int              bad;
        logic [KEY_W-1:0] k;
        len = sb.pat_len[p];
        if (len > HIST_LEN) len = HIST_LEN;
        if (len == 0) len = 1;
        bad = corrupt ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
            k = sb.pat_keys[p][8*i +: 8];
            if (i == bad) k = k ^ (8'h01 << $urandom_range(0, 7));
            send_item(OP_KEY, k);
        end
    endtask

    // Hold the write enable across all six registers; the block is idle.
    task automatic configure(input logic [NUM_PAT-1:0][PAT_W-1:0] keys,
                             input logic [LENS_W-1:0] lens,
                             input logic [NUM_PAT-1:0] en);
        cfg_reg_t              idx;
        logic [CFG_DATA_W-1:0] value;
        for (int i = 0; i <= REG_ENABLE; i++) begin
            idx = cfg_reg_t'(i);
            if (idx <= REG_KEYS_D)        value = keys[idx[1:0]];
            else if (idx == REG_LENGTHS)  value = CFG_DATA_W'(lens);
            else                          value = CFG_DATA_W'(en);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= value;
            sb.write_reg(idx, value);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Drop s_tvalid, then wait; every transfer yields one result, so an
    // empty queue means idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_masks.size() != 0) @(posedge aclk);
    endtask

    // Result side: accept and check a result, then stall for a random count.
    initial begin : result_sink
        int stall;
        wait (aresetn);
        @(posedge aclk);
        m_tready <= 1'b1;
        forever begin
            do @(posedge aclk); while (!m_tvalid);
            sb.check_mask(m_tdata);
            stall = quiet ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [NUM_PAT-1:0][PAT_W-1:0] keys;
        logic [LENS_W-1:0]             lens;
        logic [NUM_PAT-1:0]            en;
        logic [KEY_W-1:0]              alpha [4];
        int                            r;
        int                            base;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, first setting: A is a 3-key pattern, B empty (matches every
        // press), C a full 8-key pattern, D too long to ever match.
        keys[0] = 64'h0000_0000_0033_2211;
        keys[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        keys[2] = 64'hFE7F_0180_00FF_00FF;
        keys[3] = 64'h0123_4567_89AB_CDEF;
        configure(keys, 16'h9803, 4'hF);
        send_item(OP_KEY, 8'h11);
        send_item(OP_KEY, 8'h22);
        send_item(OP_KEY, 8'h33);
        send_item(OP_FLUSH, 8'hFF);     // key field ignored on flush
        send_item(OP_KEY, 8'hFF);
        send_item(OP_KEY, 8'h00);
        send_item(OP_KEY, 8'hFF);
        send_item(OP_KEY, 8'h00);
        send_item(OP_KEY, 8'h80);
        send_item(OP_KEY, 8'h01);
        send_item(OP_KEY, 8'h7F);
        send_item(OP_KEY, 8'hFE);
        drain();

        // Directed, second setting: all-zero patterns A and D against a cleared
        // history check the fill count; C is disabled and length 15.
        keys[0] = '0;
        keys[1] = '1;
        keys[2] = '0;
        keys[3] = '0;
        configure(keys, 16'h1F83, 4'b1011);
        send_item(OP_FLUSH, 8'h00);
        repeat (3) send_item(OP_KEY, 8'h00);
        repeat (8) send_item(OP_KEY, 8'hFF);

        // Random phases: a fresh setting each time, keys drawn mostly from a
        // small alphabet so that patterns recur in the press stream.
        for (int ph = 0; ph < 10; ph++) begin
            drain();
            for (int a = 0; a < 4; a++) alpha[a] = 8'($urandom_range(0, 255));
            if (ph == 2) begin
                alpha[0] = 8'h00; alpha[1] = 8'hFF; alpha[2] = 8'h00; alpha[3] = 8'hFF;
            end
            for (int p = 0; p < NUM_PAT; p++) begin
                if ($urandom_range(0, 3) == 0) begin
                    keys[p] = {$urandom, $urandom};
                end else begin
                    for (int b = 0; b < 8; b++) keys[p][8*b +: 8] = alpha[$urandom_range(0, 3)];
                end
                lens[LEN_W*p +: LEN_W] = ($urandom_range(0, 99) < 80) ?
                                         LEN_W'($urandom_range(0, 8)) :
                                         LEN_W'($urandom_range(9, 15));
            end
            if (ph == 3) lens = 16'hFFFF;
            en = (ph == 0) ? 4'hF : (ph == 1) ? 4'h0 : 4'($urandom_range(0, 15));
            configure(keys, lens, en);

            quiet = (ph % 3 == 1);
            base  = items_sent;
            while (items_sent - base < 70) begin
                r = $urandom_range(0, 99);
                if (r < 6)
                    send_item(OP_FLUSH, 8'($urandom_range(0, 255)));
                else if (r < 55)
                    play_pattern($urandom_range(0, NUM_PAT - 1), $urandom_range(0, 4) == 0);
                else if (r < 85)
                    send_item(OP_KEY, alpha[$urandom_range(0, 3)]);
                else
                    send_item(OP_KEY, 8'($urandom_range(0, 255)));
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0)
            $display("key_sequence_detector_tb: clean");
        else
            $display("key_sequence_detector_tb: errors");
        $finish;
    end

    // Hang guard, far beyond the slowest correct run.
    initial begin
        #1_000_000;
        $display("key_sequence_detector_tb: errors");
        $finish;
    end

endmodule

@@ sim.f @@
sv/ksd_pkg.sv
sv/ksd_fifo.sv
sv/ksd_front.sv
sv/ksd_back.sv
sv/key_sequence_detector.sv
dv/key_sequence_detector_tb.sv
